/* hdl/rau_pkg.sv */
// Package of the rational arithmetic unit: item types, action and status codes.
// Depends on nothing; every other file of the block uses it by scoped names.
`default_nettype none

package rau_pkg;

    localparam int VALUE_WIDTH_DEF = 32;  // default operand width
    localparam int FIELD_W         = 32;  // width of the numerator and denominator fields
    localparam int DEN_W           = 31;  // width of the result denominator
    localparam int MAG_W           = 32;  // widest operand magnitude carried in a job
    localparam int QUEUE_DEPTH     = 2;   // jobs between front and back

    typedef enum logic [2:0] {
        ACT_ADD  = 3'd0,
        ACT_SUB  = 3'd1,
        ACT_MUL  = 3'd2,
        ACT_DIV  = 3'd3,
        ACT_NEG  = 3'd4,
        ACT_INC  = 3'd5,
        ACT_DEC  = 3'd6,
        ACT_PASS = 3'd7
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_ZERO_DEN = 2'd1,
        STAT_OVERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        action_t                   action;
        logic signed [FIELD_W-1:0] a_num;
        logic signed [FIELD_W-1:0] a_den;
        logic signed [FIELD_W-1:0] b_num;
        logic signed [FIELD_W-1:0] b_den;
    } in_item_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] result_num;
        logic [DEN_W-1:0]          result_den;
        logic                      a_less;
        logic                      a_equal;
        status_t                   status;
    } out_item_t;

    // Sign-normalized operands: denominators positive, signs folded into numerators.
    typedef struct packed {
        action_t          action;
        logic             a_nneg;
        logic [MAG_W-1:0] a_nmag;
        logic [MAG_W-1:0] a_dmag;
        logic             a_dzero;
        logic             b_nneg;
        logic [MAG_W-1:0] b_nmag;
        logic [MAG_W-1:0] b_dmag;
        logic             b_dzero;
    } job_t;

endpackage

`default_nettype wire

/* hdl/rau_front.sv */
// Front part: accepts items, takes operand magnitudes and normalizes operand signs into a job.
// Depends on rau_pkg.
`default_nettype none

module rau_front #(
    parameter int VALUE_WIDTH = rau_pkg::VALUE_WIDTH_DEF
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_valid,
    output logic              s_ready,
    input  rau_pkg::in_item_t s_item,
    output logic              job_valid,
    input  wire               job_ready,
    output rau_pkg::job_t     job
);

    localparam int W = VALUE_WIDTH;

    logic          valid_reg;
    rau_pkg::job_t job_reg;
    rau_pkg::job_t job_next;

    logic [W-1:0] an_mag, ad_mag, bn_mag, bd_mag;

    function automatic logic [W-1:0] mag_of(input logic [W-1:0] x);
        mag_of = x[W-1] ? (~x + W'(1)) : x;
    endfunction

    always_comb begin
        an_mag = mag_of(s_item.a_num[W-1:0]);
        ad_mag = mag_of(s_item.a_den[W-1:0]);
        bn_mag = mag_of(s_item.b_num[W-1:0]);
        bd_mag = mag_of(s_item.b_den[W-1:0]);
        job_next.action  = s_item.action;
        job_next.a_nneg  = s_item.a_num[W-1] ^ s_item.a_den[W-1];
        job_next.a_nmag  = rau_pkg::MAG_W'(an_mag);
        job_next.a_dmag  = rau_pkg::MAG_W'(ad_mag);
        job_next.a_dzero = (ad_mag == '0);
        job_next.b_nneg  = s_item.b_num[W-1] ^ s_item.b_den[W-1];
        job_next.b_nmag  = rau_pkg::MAG_W'(bn_mag);
        job_next.b_dmag  = rau_pkg::MAG_W'(bd_mag);
        job_next.b_dzero = (bd_mag == '0);
    end

    assign s_ready   = !valid_reg || job_ready;
    assign job_valid = valid_reg;
    assign job       = job_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= 1'b1;
        end else if (job_ready) begin
            valid_reg <= 1'b0;
        end
        if (s_valid && s_ready) begin
            job_reg <= job_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/rau_queue.sv */
// Short job queue between the front and back parts.
// Depends on rau_pkg.
`default_nettype none

module rau_queue (
    input  wire           aclk,
    input  wire           aresetn,
    input  wire           push_valid,
    output logic          push_ready,
    input  rau_pkg::job_t push_job,
    output logic          pop_valid,
    input  wire           pop_ready,
    output rau_pkg::job_t pop_job
);

    localparam int DEPTH = rau_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    rau_pkg::job_t  mem [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic           push, pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

/* hdl/rau_back.sv */
// Back part: products on one shared multiplier, binary GCD, two restoring
// dividers and the range check; holds the result register. Depends on rau_pkg.
`default_nettype none

module rau_back #(
    parameter int VALUE_WIDTH = rau_pkg::VALUE_WIDTH_DEF
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                job_valid,
    output logic               job_ready,
    input  rau_pkg::job_t      job,
    output logic               m_valid,
    input  wire                m_ready,
    output rau_pkg::out_item_t m_item
);

    localparam int W   = VALUE_WIDTH;
    localparam int MW  = 2 * W;
    localparam int NW  = 2 * W + 1;
    localparam int DCW = $clog2(MW);
    localparam logic [MW-1:0] LIM = {{(MW - W + 1){1'b0}}, {(W - 1){1'b1}}};

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_COMB, ST_GCD, ST_DIV, ST_DONE
    } state_t;

    state_t             state_reg;
    rau_pkg::job_t      job_reg;
    logic [1:0]         mul_cnt_reg;
    logic [MW-1:0]      p0_reg, p1_reg, p2_reg, p3_reg;
    logic               less_reg, equal_reg, neg_reg, err_reg;
    logic [MW-1:0]      u_reg, v_reg, n_reg, d_reg, rn_reg, rd_reg;
    logic [DCW-1:0]     div_cnt_reg;
    logic               m_valid_reg;
    rau_pkg::out_item_t m_item_reg;

    // shared multiplier
    logic [W-1:0]  mul_x, mul_y;
    logic [MW-1:0] mul_p;

    always_comb begin
        case (mul_cnt_reg)
            2'd0:    begin mul_x = job_reg.a_nmag[W-1:0]; mul_y = job_reg.b_dmag[W-1:0]; end
            2'd1:    begin mul_x = job_reg.b_nmag[W-1:0]; mul_y = job_reg.a_dmag[W-1:0]; end
            2'd2:    begin mul_x = job_reg.a_dmag[W-1:0]; mul_y = job_reg.b_dmag[W-1:0]; end
            default: begin mul_x = job_reg.a_nmag[W-1:0]; mul_y = job_reg.b_nmag[W-1:0]; end
        endcase
        mul_p = MW'(mul_x) * MW'(mul_y);
    end

    // signed forms, numerator and denominator per action
    logic signed [NW-1:0] s0, s1, s3, an_s, ad_s, num_s, den_s;
    logic [MW-1:0]        num_mag, den_mag;
    logic                 err_now;

    always_comb begin
        s0   = job_reg.a_nneg ? -$signed({1'b0, p0_reg}) : $signed({1'b0, p0_reg});
        s1   = job_reg.b_nneg ? -$signed({1'b0, p1_reg}) : $signed({1'b0, p1_reg});
        s3   = (job_reg.a_nneg ^ job_reg.b_nneg) ? -$signed({1'b0, p3_reg})
                                                 : $signed({1'b0, p3_reg});
        an_s = job_reg.a_nneg ? -$signed(NW'(job_reg.a_nmag[W-1:0]))
                              : $signed(NW'(job_reg.a_nmag[W-1:0]));
        ad_s = $signed(NW'(job_reg.a_dmag[W-1:0]));
        den_s = $signed({1'b0, p2_reg});
        unique case (job_reg.action)
            rau_pkg::ACT_ADD:  num_s = s0 + s1;
            rau_pkg::ACT_SUB:  num_s = s0 - s1;
            rau_pkg::ACT_MUL:  num_s = s3;
            rau_pkg::ACT_DIV:  begin num_s = s0; den_s = s1; end
            rau_pkg::ACT_NEG:  begin num_s = -an_s; den_s = ad_s; end
            rau_pkg::ACT_INC:  begin num_s = an_s + ad_s; den_s = ad_s; end
            rau_pkg::ACT_DEC:  begin num_s = an_s - ad_s; den_s = ad_s; end
            default:           begin num_s = an_s; den_s = ad_s; end
        endcase
        num_mag = num_s[NW-1] ? MW'(-num_s) : MW'(num_s);
        den_mag = den_s[NW-1] ? MW'(-den_s) : MW'(den_s);
        err_now = job_reg.a_dzero || (den_mag == '0) ||
                  (!job_reg.action[2] && job_reg.b_dzero);
    end

    // restoring divider steps, both quotients at once
    logic [MW:0]   rn_try, rd_try;
    logic          n_ge, d_ge;

    always_comb begin
        rn_try = {rn_reg, n_reg[MW-1]};
        rd_try = {rd_reg, d_reg[MW-1]};
        n_ge   = (rn_try >= {1'b0, v_reg});
        d_ge   = (rd_try >= {1'b0, v_reg});
    end

    // range check and result
    logic               res_neg, ovf;
    logic [W-1:0]       rnum_w;
    rau_pkg::out_item_t res;

    always_comb begin
        res_neg = neg_reg && (n_reg != '0);
        ovf     = (d_reg > LIM) || (n_reg > (LIM + MW'(res_neg)));
        rnum_w  = res_neg ? -n_reg[W-1:0] : n_reg[W-1:0];
        res.a_less  = less_reg;
        res.a_equal = equal_reg;
        if (err_reg) begin
            res.result_num = '0;
            res.result_den = '0;
            res.status     = rau_pkg::STAT_ZERO_DEN;
        end else if (ovf) begin
            res.result_num = '0;
            res.result_den = '0;
            res.status     = rau_pkg::STAT_OVERFLOW;
        end else begin
            res.result_num = rau_pkg::FIELD_W'(signed'(rnum_w));
            res.result_den = rau_pkg::DEN_W'(d_reg);
            res.status     = rau_pkg::STAT_OK;
        end
    end

    logic load_out;
    assign load_out  = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
    assign job_ready = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (job_valid) begin
                        job_reg     <= job;
                        mul_cnt_reg <= '0;
                        state_reg   <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    case (mul_cnt_reg)
                        2'd0:    p0_reg <= mul_p;
                        2'd1:    p1_reg <= mul_p;
                        2'd2:    p2_reg <= mul_p;
                        default: p3_reg <= mul_p;
                    endcase
                    mul_cnt_reg <= mul_cnt_reg + 2'd1;
                    if (mul_cnt_reg == 2'd3) begin
                        state_reg <= ST_COMB;
                    end
                end
                ST_COMB: begin
                    less_reg  <= (s0 < s1);
                    equal_reg <= (s0 == s1);
                    neg_reg   <= num_s[NW-1] ^ den_s[NW-1];
                    err_reg   <= err_now;
                    u_reg     <= num_mag;
                    v_reg     <= den_mag;
                    n_reg     <= num_mag;
                    d_reg     <= den_mag;
                    state_reg <= err_now ? ST_DONE : ST_GCD;
                end
                ST_GCD: begin
                    if (u_reg == '0) begin
                        rn_reg      <= '0;
                        rd_reg      <= '0;
                        div_cnt_reg <= '0;
                        state_reg   <= ST_DIV;
                    end else if (!u_reg[0] && !v_reg[0]) begin
                        // shared factor of two: drop it from the operands too
                        u_reg <= u_reg >> 1;
                        v_reg <= v_reg >> 1;
                        n_reg <= n_reg >> 1;
                        d_reg <= d_reg >> 1;
                    end else if (!u_reg[0]) begin
                        u_reg <= u_reg >> 1;
                    end else if (!v_reg[0]) begin
                        v_reg <= v_reg >> 1;
                    end else if (u_reg >= v_reg) begin
                        u_reg <= (u_reg - v_reg) >> 1;
                    end else begin
                        v_reg <= (v_reg - u_reg) >> 1;
                    end
                end
                ST_DIV: begin
                    rn_reg      <= n_ge ? MW'(rn_try - {1'b0, v_reg}) : MW'(rn_try);
                    rd_reg      <= d_ge ? MW'(rd_try - {1'b0, v_reg}) : MW'(rd_try);
                    n_reg       <= {n_reg[MW-2:0], n_ge};
                    d_reg       <= {d_reg[MW-2:0], d_ge};
                    div_cnt_reg <= div_cnt_reg + DCW'(1);
                    if (div_cnt_reg == DCW'(MW - 1)) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (load_out) begin
                        m_item_reg <= res;
                        state_reg  <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_gcd_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_GCD || state_reg == ST_DIV) |-> (v_reg != '0))
        else $error("gcd divisor became zero");
    a_ok_den: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_item_reg.status == rau_pkg::STAT_OK) |-> (m_item_reg.result_den != '0))
        else $error("ok result with zero denominator");
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_item_reg.status != rau_pkg::STAT_OK) |->
        (m_item_reg.result_num == '0 && m_item_reg.result_den == '0))
        else $error("error result carries a value");
`endif

endmodule

`default_nettype wire

/* hdl/rational_arithmetic_unit.sv */
// Top level of the rational arithmetic unit: front, job queue and back part.
// Depends on rau_pkg, rau_front, rau_queue and rau_back.
//
//   channel   ports                      payload
//   input     s_valid, s_ready, s_item   rau_pkg::in_item_t
//   result    m_valid, m_ready, m_item   rau_pkg::out_item_t
//
// In the back part an item passes through these steps: taking the job, four
// products on one shared multiplier, combining them, the binary GCD loop (its
// last step finding a zero operand), the two restoring dividers side by side
// for a 2*VALUE_WIDTH-bit quotient, and the load of the result register, which
// waits until any earlier result is taken. The front register and the queue
// lie ahead of the back part, which takes one job at a time.
// Items with a zero denominator skip the GCD and divide loops.
// Reset is synchronous and active low on aclk; it empties the queue and result.
// The front and the queue keep taking items while the back part works or a
// result waits on m_ready, until the queue and the front register are full.
`default_nettype none

module rational_arithmetic_unit #(
    parameter int VALUE_WIDTH = rau_pkg::VALUE_WIDTH_DEF
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_valid,
    output logic               s_ready,
    input  rau_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  wire                m_ready,
    output rau_pkg::out_item_t m_item
);

    // front to queue
    logic          fq_valid, fq_ready;
    rau_pkg::job_t fq_job;
    // queue to back
    logic          qb_valid, qb_ready;
    rau_pkg::job_t qb_job;

    // classify and sign-normalize the operands
    rau_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .job_valid (fq_valid),
        .job_ready (fq_ready),
        .job       (fq_job)
    );

    // hold jobs so the front stalls independently of the back
    rau_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_job   (fq_job),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_job    (qb_job)
    );

    // multiply, reduce and check range
    rau_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (qb_valid),
        .job_ready (qb_ready),
        .job       (qb_job),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule

`default_nettype wire
